[hdl/asd_pkg.sv]
// Shared constants and types for the accelerometer step detector.
// Depends on nothing; the interfaces, the divider lane and the unit refer to it by scoped names.
package asd_pkg;

    // Field widths of the sample and result beats, and of the root datapath.
    localparam int SAMPLE_W = 16;
    localparam int COUNT_W  = 32;
    localparam int MAG_W    = 16;
    localparam int RAD_W    = 32;
    localparam int REM_W    = MAG_W + 2;

    // Default depth of the sample window.
    localparam int WINDOW_DEF = 25;

    // Configuration port.
    localparam int THR_W      = 13;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = THR_W;

    localparam logic [CFG_IDX_W-1:0] CFG_HIGH_THR = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LOW_THR  = 1'd1;

    localparam logic [THR_W-1:0] HIGH_THR_RST = 13'd270;
    localparam logic [THR_W-1:0] LOW_THR_RST  = 13'd235;

    // Control from the sequencer to the three divider lanes.
    typedef struct packed {
        logic load;
        logic step;
    } div_ctrl_t;

endpackage

[hdl/asd_if.sv]
// Handshake interfaces for the sample input and the result output channels.
// Depends on asd_pkg for the field widths.
interface asd_sample_if;
    logic                                valid;
    logic                                ready;
    logic signed [asd_pkg::SAMPLE_W-1:0] accel_x;
    logic signed [asd_pkg::SAMPLE_W-1:0] accel_y;
    logic signed [asd_pkg::SAMPLE_W-1:0] accel_z;

    modport source (output valid, accel_x, accel_y, accel_z, input ready);
    modport sink   (input valid, accel_x, accel_y, accel_z, output ready);
endinterface

interface asd_result_if;
    logic                                valid;
    logic                                ready;
    logic        [asd_pkg::COUNT_W-1:0]  step_count;
    logic                                is_stepping;
    logic signed [asd_pkg::SAMPLE_W-1:0] mean_x;
    logic signed [asd_pkg::SAMPLE_W-1:0] mean_y;
    logic signed [asd_pkg::SAMPLE_W-1:0] mean_z;
    logic        [asd_pkg::MAG_W-1:0]    magnitude;

    modport source (output valid, step_count, is_stepping, mean_x, mean_y, mean_z, magnitude,
                    input ready);
    modport sink   (input valid, step_count, is_stepping, mean_x, mean_y, mean_z, magnitude,
                     output ready);
endinterface

[hdl/asd_ram.sv]
// Generic single-port-write, single-port-read RAM with a registered read.
// Depends on nothing.
module asd_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 25
) (
    input  logic                                  clk,
    input  logic                                  we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                      wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                      rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port and registered read port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

[hdl/asd_div_lane.sv]
// One divider lane: divides a signed window sum by the window depth, truncating
// toward zero, by multiplying with a fixed-point reciprocal.
// Depends on asd_pkg.
module asd_div_lane #(
    parameter int WINDOW = asd_pkg::WINDOW_DEF,
    parameter int SUM_W  = asd_pkg::SAMPLE_W + ((WINDOW > 1) ? $clog2(WINDOW) : 0)
) (
    input  logic                                clk,
    input  asd_pkg::div_ctrl_t                  ctrl,
    input  logic signed [SUM_W-1:0]             sum,
    output logic signed [asd_pkg::SAMPLE_W-1:0] mean
);

    // The reciprocal is rounded up and carries enough fraction bits that the
    // product gives the exact floor quotient for every sum magnitude.
    localparam int LOG_W   = (WINDOW > 1) ? $clog2(WINDOW) : 0;
    localparam int SHIFT   = SUM_W + LOG_W;
    localparam int RECIP_W = SUM_W + 1;
    localparam int PROD_W  = SUM_W + RECIP_W;
    localparam longint unsigned RECIP_FULL =
        ((64'd1 << SHIFT) + 64'(WINDOW) - 64'd1) / 64'(WINDOW);
    localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(RECIP_FULL);

    logic [SUM_W-1:0]             abs_reg;
    logic                         neg_reg;
    logic [PROD_W-1:0]            prod_reg;
    logic [SUM_W-1:0]             sum_abs;
    logic [asd_pkg::SAMPLE_W-1:0] q_low;

    // Divide the magnitude and put the sign back at the end.
    assign sum_abs = sum[SUM_W-1] ? (SUM_W'(~sum) + SUM_W'(1)) : SUM_W'(sum);

    // The load control captures the magnitude, the step control forms the product.
    always_ff @(posedge clk)
    begin
        if (ctrl.load)
        begin
            abs_reg <= sum_abs;
            neg_reg <= sum[SUM_W-1];
        end
        else if (ctrl.step)
        begin
            prod_reg <= PROD_W'(abs_reg) * PROD_W'(RECIP);
        end
    end

    // The quotient never exceeds 32768, so the low bits carry the whole mean.
    assign q_low = prod_reg[SHIFT +: asd_pkg::SAMPLE_W];
    assign mean  = signed'(neg_reg ? (~q_low + asd_pkg::SAMPLE_W'(1)) : q_low);

endmodule

[hdl/accel_step_detector_unit.sv]
// Accelerometer step detector: moving-average magnitude with hysteresis.
// One sample at a time: a new beat is taken only in the idle state, once the window
// update, the reciprocal divide, the squaring and the 16-step root of the last one
// are through; a stalled result beat holds off both the result and the next sample.
// Reset clears the window (per-entry valid bits), sums, pointer, step state and
// the thresholds to 270 and 235 at once; no clearing pass is needed.
module accel_step_detector_unit #(
    parameter int WINDOW = asd_pkg::WINDOW_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [asd_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [asd_pkg::CFG_DATA_W-1:0]   cfg_data,
    asd_sample_if.sink                       samples,
    asd_result_if.source                     results
);

    localparam int SW    = asd_pkg::SAMPLE_W;
    localparam int SUM_W = SW + ((WINDOW > 1) ? $clog2(WINDOW) : 0);
    localparam int PTR_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int CNT_W = $clog2((SUM_W > asd_pkg::MAG_W) ? SUM_W : asd_pkg::MAG_W);
    localparam int WORD_W = 3 * SW;

    typedef enum logic [6:0] {
        ST_IDLE   = 7'b0000001,
        ST_UPDATE = 7'b0000010,
        ST_SETUP  = 7'b0000100,
        ST_DIVIDE = 7'b0001000,
        ST_SQUARE = 7'b0010000,
        ST_ROOT   = 7'b0100000,
        ST_DONE   = 7'b1000000
    } state_t;

    state_t state_reg, state_next;

    logic [CNT_W-1:0]            cnt_reg, cnt_next;
    logic [PTR_W-1:0]            ptr_reg;
    logic [WINDOW-1:0]           win_valid_reg;
    logic signed [SW-1:0]        smp_x_reg, smp_y_reg, smp_z_reg;
    logic signed [SUM_W-1:0]     sum_x_reg, sum_y_reg, sum_z_reg;
    logic [asd_pkg::THR_W-1:0]   high_thr_reg, low_thr_reg;
    logic                        stepping_reg;
    logic [asd_pkg::COUNT_W-1:0] steps_reg;

    logic [asd_pkg::RAD_W-1:0]   prod_reg;
    logic [asd_pkg::RAD_W-1:0]   rad_reg;
    logic [asd_pkg::REM_W-1:0]   rem_reg;
    logic [asd_pkg::MAG_W-1:0]   root_reg;

    logic                        out_valid_reg;
    logic [asd_pkg::COUNT_W-1:0] out_count_reg;
    logic                        out_stepping_reg;
    logic signed [SW-1:0]        out_mean_x_reg, out_mean_y_reg, out_mean_z_reg;
    logic [asd_pkg::MAG_W-1:0]   out_mag_reg;

    logic                        accept;
    logic                        out_free;
    logic                        ram_we;
    logic [WORD_W-1:0]           ram_rdata;
    logic [WORD_W-1:0]           old_word;
    logic signed [SW-1:0]        old_x, old_y, old_z;
    asd_pkg::div_ctrl_t          div_ctrl;
    logic signed [SW-1:0]        mean_x, mean_y, mean_z;
    logic signed [SW-1:0]        sq_sel;
    logic signed [2*SW-1:0]      sq_val;
    logic [asd_pkg::REM_W-1:0]   rem_trial;
    logic [asd_pkg::REM_W-1:0]   root_trial;
    logic                        root_ge;
    logic                        high_hit;
    logic                        low_hit;

    assign accept   = samples.valid && samples.ready;
    assign out_free = !out_valid_reg || results.ready;
    assign samples.ready = (state_reg == ST_IDLE);

    // Sample window memory; the read address follows the pointer, so the
    // oldest entry is ready in the cycle after the beat is taken.
    assign ram_we = (state_reg == ST_UPDATE);

    asd_ram #(
        .WIDTH (WORD_W),
        .DEPTH (WINDOW)
    ) u_window (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ptr_reg),
        .wdata ({smp_x_reg, smp_y_reg, smp_z_reg}),
        .raddr (ptr_reg),
        .rdata (ram_rdata)
    );

    // An entry never written since reset reads as zero.
    assign old_word = win_valid_reg[ptr_reg] ? ram_rdata : '0;
    assign old_x    = signed'(old_word[3*SW-1:2*SW]);
    assign old_y    = signed'(old_word[2*SW-1:SW]);
    assign old_z    = signed'(old_word[SW-1:0]);

    // Three divider lanes run side by side.
    assign div_ctrl.load = (state_reg == ST_SETUP);
    assign div_ctrl.step = (state_reg == ST_DIVIDE);

    asd_div_lane #(.WINDOW (WINDOW), .SUM_W (SUM_W)) u_div_x (
        .clk (clk), .ctrl (div_ctrl), .sum (sum_x_reg), .mean (mean_x)
    );
    asd_div_lane #(.WINDOW (WINDOW), .SUM_W (SUM_W)) u_div_y (
        .clk (clk), .ctrl (div_ctrl), .sum (sum_y_reg), .mean (mean_y)
    );
    asd_div_lane #(.WINDOW (WINDOW), .SUM_W (SUM_W)) u_div_z (
        .clk (clk), .ctrl (div_ctrl), .sum (sum_z_reg), .mean (mean_z)
    );

    // One shared squarer walks the three means.
    always_comb
    begin
        case (cnt_reg[1:0])
            2'd0:    sq_sel = mean_x;
            2'd1:    sq_sel = mean_y;
            2'd2:    sq_sel = mean_z;
            default: sq_sel = '0;
        endcase
    end

    assign sq_val = sq_sel * sq_sel;

    // Digit-by-digit square root, two radicand bits per cycle.
    assign rem_trial  = {rem_reg[asd_pkg::REM_W-3:0], rad_reg[asd_pkg::RAD_W-1 -: 2]};
    assign root_trial = {root_reg, 2'b01};
    assign root_ge    = (rem_trial >= root_trial);

    // Hysteresis: the high test wins when it fires.
    assign high_hit = (root_reg >= asd_pkg::MAG_W'(high_thr_reg)) && !stepping_reg;
    assign low_hit  = (root_reg <= asd_pkg::MAG_W'(low_thr_reg));

    // Sequencer.
    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_UPDATE;
                end
            end
            ST_UPDATE:
            begin
                state_next = ST_SETUP;
            end
            ST_SETUP:
            begin
                state_next = ST_DIVIDE;
                cnt_next   = '0;
            end
            ST_DIVIDE:
            begin
                state_next = ST_SQUARE;
                cnt_next   = '0;
            end
            ST_SQUARE:
            begin
                if (cnt_reg == CNT_W'(3))
                begin
                    state_next = ST_ROOT;
                    cnt_next   = '0;
                end
                else
                begin
                    cnt_next = cnt_reg + CNT_W'(1);
                end
            end
            ST_ROOT:
            begin
                if (cnt_reg == CNT_W'(asd_pkg::MAG_W - 1))
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    cnt_next = cnt_reg + CNT_W'(1);
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control state, window bookkeeping and step state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            ptr_reg       <= '0;
            win_valid_reg <= '0;
            sum_x_reg     <= '0;
            sum_y_reg     <= '0;
            sum_z_reg     <= '0;
            stepping_reg  <= 1'b0;
            steps_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;

            if (state_reg == ST_UPDATE)
            begin
                sum_x_reg <= sum_x_reg + SUM_W'(smp_x_reg) - SUM_W'(old_x);
                sum_y_reg <= sum_y_reg + SUM_W'(smp_y_reg) - SUM_W'(old_y);
                sum_z_reg <= sum_z_reg + SUM_W'(smp_z_reg) - SUM_W'(old_z);
                win_valid_reg[ptr_reg] <= 1'b1;
                if (ptr_reg == PTR_W'(WINDOW - 1))
                begin
                    ptr_reg <= '0;
                end
                else
                begin
                    ptr_reg <= ptr_reg + PTR_W'(1);
                end
            end

            if ((state_reg == ST_DONE) && out_free)
            begin
                if (high_hit)
                begin
                    stepping_reg <= 1'b1;
                    steps_reg    <= steps_reg + asd_pkg::COUNT_W'(1);
                end
                else if (low_hit)
                begin
                    stepping_reg <= 1'b0;
                end
                out_valid_reg <= 1'b1;
            end
            else if (results.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Thresholds.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            high_thr_reg <= asd_pkg::HIGH_THR_RST;
            low_thr_reg  <= asd_pkg::LOW_THR_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                asd_pkg::CFG_HIGH_THR: high_thr_reg <= cfg_data;
                asd_pkg::CFG_LOW_THR:  low_thr_reg  <= cfg_data;
                default:               ;
            endcase
        end
    end

    // Datapath registers: sample capture, squares, root and the result beat.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            smp_x_reg <= samples.accel_x;
            smp_y_reg <= samples.accel_y;
            smp_z_reg <= samples.accel_z;
        end

        case (state_reg)
            ST_SETUP:
            begin
                prod_reg <= '0;
                rad_reg  <= '0;
                rem_reg  <= '0;
                root_reg <= '0;
            end
            ST_SQUARE:
            begin
                prod_reg <= asd_pkg::RAD_W'(unsigned'(sq_val));
                rad_reg  <= rad_reg + prod_reg;
            end
            ST_ROOT:
            begin
                rad_reg  <= {rad_reg[asd_pkg::RAD_W-3:0], 2'b00};
                rem_reg  <= root_ge ? (rem_trial - root_trial) : rem_trial;
                root_reg <= {root_reg[asd_pkg::MAG_W-2:0], root_ge};
            end
            default:
            begin
            end
        endcase

        if ((state_reg == ST_DONE) && out_free)
        begin
            out_count_reg    <= high_hit ? (steps_reg + asd_pkg::COUNT_W'(1)) : steps_reg;
            out_stepping_reg <= high_hit ? 1'b1 : (low_hit ? 1'b0 : stepping_reg);
            out_mean_x_reg   <= mean_x;
            out_mean_y_reg   <= mean_y;
            out_mean_z_reg   <= mean_z;
            out_mag_reg      <= root_reg;
        end
    end

    // Result beat.
    assign results.valid       = out_valid_reg;
    assign results.step_count  = out_count_reg;
    assign results.is_stepping = out_stepping_reg;
    assign results.mean_x      = out_mean_x_reg;
    assign results.mean_y      = out_mean_y_reg;
    assign results.mean_z      = out_mean_z_reg;
    assign results.magnitude   = out_mag_reg;

`ifndef SYNTHESIS
    // A taken sample always goes straight to the window update.
    assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (state_reg == ST_UPDATE))
        else $error("sample beat did not start the window update");

    // The step count moves only on a rising edge of the stepping flag.
    assert property (@(posedge clk) disable iff (!rst_n)
        (steps_reg != $past(steps_reg)) |-> (stepping_reg && !$past(stepping_reg)))
        else $error("step count changed without a new step");

    // The window pointer stays inside the window.
    assert property (@(posedge clk) disable iff (!rst_n)
        ptr_reg <= PTR_W'(WINDOW - 1))
        else $error("window pointer out of range");

    // A finished item waits while the previous result is still held.
    assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == ST_DONE) && !out_free) |=> (state_reg == ST_DONE))
        else $error("result overwritten while stalled");
`endif

endmodule
